// File: design/median_3x3_filter_defines.svh
// assertion macros for the 3x3 median filter checker
// no dependencies; the including scope provides clk and rst
`ifndef MEDIAN_3X3_FILTER_DEFINES_SVH
`define MEDIAN_3X3_FILTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define M3F_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define M3F_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/m3f_pkg.sv
// shared types and constants for the 3x3 median filter
// no dependencies; used via m3f_pkg:: names by the sorter and top level
package m3f_pkg;

  localparam int FW_BITS       = 12;
  localparam int FH_BITS       = 16;
  localparam int CFG_DATA_BITS = 16;

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // median-of-nine exchange network, one row per pipeline layer
  localparam int MED_LAYERS = 7;
  localparam int MED_PAIRS  = 3;
  localparam int MED_CENTER = 4;

  localparam logic [3:0] MED_LO [MED_LAYERS][MED_PAIRS] = '{
    '{4'd1, 4'd4, 4'd7},
    '{4'd0, 4'd3, 4'd6},
    '{4'd1, 4'd4, 4'd7},
    '{4'd0, 4'd5, 4'd4},
    '{4'd3, 4'd1, 4'd2},
    '{4'd4, 4'd4, 4'd6},
    '{4'd4, 4'd0, 4'd0}
  };

  localparam logic [3:0] MED_HI [MED_LAYERS][MED_PAIRS] = '{
    '{4'd2, 4'd5, 4'd8},
    '{4'd1, 4'd4, 4'd7},
    '{4'd2, 4'd5, 4'd8},
    '{4'd3, 4'd8, 4'd7},
    '{4'd6, 4'd4, 4'd5},
    '{4'd7, 4'd2, 4'd4},
    '{4'd2, 4'd0, 4'd0}
  };

  localparam logic [1:0] MED_NPAIR [MED_LAYERS] = '{
    2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1
  };

  // per-result control that rides along the sorting pipeline
  typedef struct packed {
    logic border;
    logic last;
  } m3f_ctl_t;

endpackage

// File: design/m3f_line_buf.sv
// two line stores (two rows back and one row back), one entry per column
// synchronous read with registered data; depends on nothing else
module m3f_line_buf #(
  parameter int DEPTH = 2048,
  parameter int DW    = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_upper,
  output logic [DW-1:0]            rd_middle,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_upper,
  input  logic [DW-1:0]            wr_middle
);

  logic [DW-1:0] mem_upper  [DEPTH];
  logic [DW-1:0] mem_middle [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_upper[wr_addr]  <= wr_upper;
      mem_middle[wr_addr] <= wr_middle;
    end
  end

  // read-before-write on a shared address; caller forwards
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_upper  <= mem_upper[rd_addr];
      rd_middle <= mem_middle[rd_addr];
    end
  end

endmodule

// File: design/m3f_median_sort.sv
// pipelined median-of-nine exchange network, one register per layer
// depends on m3f_pkg for the network table and the control struct
module m3f_median_sort #(
  parameter int PIXEL_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  m3f_pkg::m3f_ctl_t             in_ctl,
  input  logic [8:0][PIXEL_BITS-1:0]    win_in,
  output logic                          out_valid,
  output logic [PIXEL_BITS-1:0]         out_pixel,
  output logic                          out_last
);

  localparam int NL = m3f_pkg::MED_LAYERS;

  logic [8:0][PIXEL_BITS-1:0] stg [1:NL];
  logic [PIXEL_BITS-1:0]      ctr [1:NL];
  m3f_pkg::m3f_ctl_t          ctl [1:NL];
  logic [NL:1]                vld;

  function automatic logic [8:0][PIXEL_BITS-1:0] net_layer(
    input logic [8:0][PIXEL_BITS-1:0] din,
    input int                         lay
  );
    logic [8:0][PIXEL_BITS-1:0] d;
    logic [PIXEL_BITS-1:0]      a;
    logic [PIXEL_BITS-1:0]      b;
    d = din;
    for (int k = 0; k < m3f_pkg::MED_PAIRS; k++) begin
      if (k < int'(m3f_pkg::MED_NPAIR[lay])) begin
        a = d[m3f_pkg::MED_LO[lay][k]];
        b = d[m3f_pkg::MED_HI[lay][k]];
        if (a > b) begin
          d[m3f_pkg::MED_LO[lay][k]] = b;
          d[m3f_pkg::MED_HI[lay][k]] = a;
        end
      end
    end
    return d;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      stg[1] <= net_layer(win_in, 0);
      ctr[1] <= win_in[m3f_pkg::MED_CENTER];
      ctl[1] <= in_ctl;
      for (int l = 1; l < NL; l++) begin
        stg[l+1] <= net_layer(stg[l], l);
        ctr[l+1] <= ctr[l];
        ctl[l+1] <= ctl[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NL-1:1], in_valid};
    end
  end

  assign out_valid = vld[NL];
  assign out_pixel = ctl[NL].border ? ctr[NL] : stg[NL][m3f_pkg::MED_CENTER];
  assign out_last  = ctl[NL].last;

endmodule

// File: design/median_3x3_filter.sv
// 3x3 median filter over a raster pixel stream. Takes one request per clock
// and gives one result per clock while the output side keeps up; the rate is
// set by the single read and write port pair of each line store. A result
// leaves after the request that completes its window, by way of the
// line-store read, the window update, the seven layers of the sorting
// network and the output register in turn. Border pixels pass through
// unchanged. Each frame needs frame_width+1 flush requests (tuser low) after
// its last pixel to drain the final row; flush requests inside the frame are
// taken and dropped. Line stores are not cleared after reset. Write
// frame_width and frame_height only while no frame is in progress.
// Depends on m3f_pkg, m3f_line_buf and m3f_median_sort.
module median_3x3_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_axis_tdata,  // pixel
  input  logic                                  s_axis_tuser,  // is_pixel
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]        m_axis_tdata,  // out_pixel
  output logic                                  m_axis_tlast,  // frame_last
  input  logic                                  cfg_we,
  input  logic [0:0]                            cfg_index,
  input  logic [m3f_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int CMPW       = (CW + 1 > m3f_pkg::FW_BITS) ? CW + 1 : m3f_pkg::FW_BITS;
  localparam int HB         = m3f_pkg::FH_BITS;

  // configuration
  logic [m3f_pkg::FW_BITS-1:0] frame_width;
  logic [HB-1:0]               frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= m3f_pkg::FW_BITS'(640);
      frame_height <= HB'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        m3f_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[m3f_pkg::FW_BITS-1:0];
        m3f_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data[HB-1:0];
        default: ;
      endcase
    end
  end

  // position counters
  logic [CW-1:0] in_column, in_column_next;
  logic [HB-1:0] in_row, in_row_next;
  logic [CW-1:0] out_column, out_column_next;
  logic [HB-1:0] out_row, out_row_next;

  logic            en;
  logic            accept;
  logic [CMPW-1:0] fw_ext, eff_w, in_col_p1, out_col_p1;
  logic [HB-1:0]   eff_h, row_cap;
  logic [HB:0]     out_row_p1, h_ext;
  logic            in_frame, drop, first, emit, border, last;
  logic [PIXEL_BITS-1:0] v_in;

  // stage 1: line-store data arrives
  logic                  s1_valid;
  logic [CW-1:0]         s1_x;
  logic [PIXEL_BITS-1:0] s1_v;
  logic                  s1_emit;
  m3f_pkg::m3f_ctl_t     s1_ctl;
  logic                  s1_fwd;
  logic [PIXEL_BITS-1:0] s1_fwd_up, s1_fwd_mid;
  logic [PIXEL_BITS-1:0] rd_upper, rd_middle, up_eff, mid_eff;

  // stage 2: window holds this item's neighborhood
  logic                             s2_valid;
  m3f_pkg::m3f_ctl_t                s2_ctl;
  logic [2:0][2:0][PIXEL_BITS-1:0]  win;

  // sorter and output
  logic                  med_valid;
  logic [PIXEL_BITS-1:0] med_pixel;
  logic                  med_last;
  logic                  out_valid, skid_valid;
  logic [PIXEL_BITS-1:0] out_pixel, skid_pixel;
  logic                  out_last, skid_last;

  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;

  always_comb begin
    fw_ext = CMPW'(frame_width);
    if (fw_ext == '0) begin
      eff_w = CMPW'(1);
    end else if (fw_ext > CMPW'(MAX_WIDTH)) begin
      eff_w = CMPW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    eff_h      = (frame_height == '0) ? HB'(1) : frame_height;
    row_cap    = (eff_h < HB'(2)) ? HB'(2) : eff_h;
    in_frame   = in_row < eff_h;
    drop       = in_frame && !s_axis_tuser;
    v_in       = in_frame ? s_axis_tdata[PIXEL_BITS-1:0] : '0;
    in_col_p1  = CMPW'(in_column) + CMPW'(1);
    out_col_p1 = CMPW'(out_column) + CMPW'(1);
    out_row_p1 = {1'b0, out_row} + (HB+1)'(1);
    h_ext      = {1'b0, eff_h};

    // first result waits for the input one row and one pixel later
    if (eff_w == CMPW'(1)) begin
      first = (in_row == HB'(2));
    end else begin
      first = (in_row == HB'(1)) && (in_column == CW'(1));
    end
    emit   = first || (out_row != '0) || (out_column != '0);
    border = !((out_row != '0) && (out_row_p1 < h_ext) &&
               (out_column != '0) && (out_col_p1 < eff_w));
    last   = (out_row_p1 >= h_ext) && (out_col_p1 >= eff_w);

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (accept && !drop) begin
      if (in_col_p1 >= eff_w) begin
        in_column_next = '0;
        if (in_row < row_cap) begin
          in_row_next = in_row + HB'(1);
        end
      end else begin
        in_column_next = in_col_p1[CW-1:0];
      end
      if (emit) begin
        if (last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_col_p1 >= eff_w) begin
          out_column_next = '0;
          if (out_row != '1) begin
            out_row_next = out_row_p1[HB-1:0];
          end
        end else begin
          out_column_next = out_col_p1[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  m3f_line_buf #(
    .DEPTH (MAX_WIDTH),
    .DW    (PIXEL_BITS)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (in_column),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (s1_valid && en),
    .wr_addr   (s1_x),
    .wr_upper  (mid_eff),
    .wr_middle (s1_v)
  );

  // the write of the item ahead lands in the same cycle as this read
  assign up_eff  = s1_fwd ? s1_fwd_up  : rd_upper;
  assign mid_eff = s1_fwd ? s1_fwd_mid : rd_middle;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept && !drop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x          <= in_column;
      s1_v          <= v_in;
      s1_emit       <= emit;
      s1_ctl.border <= border;
      s1_ctl.last   <= last;
      s1_fwd        <= s1_valid && (in_column == s1_x);
      s1_fwd_up     <= mid_eff;
      s1_fwd_mid    <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win      <= '0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_emit;
      if (s1_valid) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[0][2] <= up_eff;
        win[1][2] <= mid_eff;
        win[2][2] <= s1_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ctl <= s1_ctl;
    end
  end

  m3f_median_sort #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_median_sort (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s2_valid),
    .in_ctl    (s2_ctl),
    .win_in    (win),
    .out_valid (med_valid),
    .out_pixel (med_pixel),
    .out_last  (med_last)
  );

  // output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (med_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        out_pixel <= skid_pixel;
        out_last  <= skid_last;
      end
    end else if (med_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_pixel <= med_pixel;
        out_last  <= med_last;
      end else begin
        skid_pixel <= med_pixel;
        skid_last  <= med_last;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_BITS'(out_pixel);
  assign m_axis_tlast  = out_last;

endmodule

// File: design/m3f_checker.sv
// port-level checker for the 3x3 median filter, bound to the top level
// depends on median_3x3_filter_defines.svh for the assertion macros
`include "median_3x3_filter_defines.svh"

module m3f_checker #(
  parameter int TDATA_BITS = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [TDATA_BITS-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic        in_acc;
  logic        out_acc;
  logic [31:0] pending;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests taken minus results delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 32'(in_acc) - 32'(out_acc);
    end
  end

  // a stalled result holds its payload
  `M3F_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")

  // every result is caused by an earlier request
  `M3F_ASSERT_NOW(a_no_spurious, out_acc, pending != 32'd0, "result without a pending request")

  // nothing leaves right after reset
  `M3F_ASSERT_NOW(a_idle_after_reset, $past(rst), !m_axis_tvalid, "result right after reset")

  // input back-pressure only while a result is waiting
  `M3F_ASSERT_NOW(a_ready_low, !s_axis_tready, m_axis_tvalid, "input stalled with no result waiting")

endmodule

bind median_3x3_filter m3f_checker #(
  .TDATA_BITS (TDATA_BITS)
) u_m3f_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_median_3x3_filter.sv
// self-checking testbench for median_3x3_filter: streams grayscale frames of many sizes
// through the request and result streams and compares every result with a local model or a typed value
// depends on m3f_pkg and median_3x3_filter
module tb_median_3x3_filter;

  localparam int unsigned MAX_COLS      = 2048;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          CYCLE_LIMIT   = 600000;
  localparam int          ITEMS_PER_MODE = 560;
  localparam int          DIRECTED_ROWS = 15;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } median_out_t;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_TYPED,
    CHK_NONE
  } check_kind_t;

  typedef struct packed {
    logic [7:0]  pix;
    logic        is_pix;
    check_kind_t kind;
    median_out_t want;
  } directed_row_t;

  // 3x3 frame; the centre median comes from the model, the rest is pass-through
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{8'd0,    1'b1, CHK_NONE,  '{8'd0,   1'b0}},
    '{8'd255,  1'b1, CHK_NONE,  '{8'd0,   1'b0}},
    '{8'd7,    1'b1, CHK_NONE,  '{8'd0,   1'b0}},
    '{8'hA5,   1'b0, CHK_NONE,  '{8'd0,   1'b0}},  // flush inside the frame is dropped
    '{8'd200,  1'b1, CHK_NONE,  '{8'd0,   1'b0}},
    '{8'd9,    1'b1, CHK_TYPED, '{8'd0,   1'b0}},
    '{8'd50,   1'b1, CHK_TYPED, '{8'd255, 1'b0}},
    '{8'd255,  1'b1, CHK_TYPED, '{8'd7,   1'b0}},
    '{8'd0,    1'b1, CHK_TYPED, '{8'd200, 1'b0}},
    '{8'd128,  1'b1, CHK_MODEL, '{8'd0,   1'b0}},
    '{8'd77,   1'b1, CHK_TYPED, '{8'd50,  1'b0}},  // pixel past the frame acts as flush
    '{8'd0,    1'b0, CHK_TYPED, '{8'd255, 1'b0}},
    '{8'd0,    1'b0, CHK_TYPED, '{8'd0,   1'b0}},
    '{8'd0,    1'b0, CHK_TYPED, '{8'd128, 1'b1}},
    '{8'd0,    1'b0, CHK_NONE,  '{8'd0,   1'b0}}   // extra flush after the frame
  };

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [7:0]                 s_axis_tdata = '0;   // pixel
  logic                       s_axis_tuser = 1'b0; // is_pixel
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [7:0]                 m_axis_tdata;        // out_pixel
  logic                       m_axis_tlast;        // frame_last
  logic                       cfg_we = 1'b0;
  logic [0:0]                 cfg_index = m3f_pkg::REG_FRAME_WIDTH;
  logic [m3f_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  median_3x3_filter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // model state
  logic [m3f_pkg::FW_BITS-1:0] width_reg  = 12'd640;
  logic [m3f_pkg::FH_BITS-1:0] height_reg = 16'd480;
  logic [7:0]         rows_back2 [MAX_COLS];
  logic [7:0]         rows_back1 [MAX_COLS];
  logic [7:0]         nbhd [3][3];
  int unsigned        feed_col, feed_row, emit_col, emit_row;

  median_out_t expected_px [$];
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int errors = 0;
  int requests = 0;
  int results_seen = 0;
  int frames_done = 0;
  int reg_writes = 0;
  int random_items = 0;
  int cycles = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < MAX_COLS; i++) begin
      rows_back2[i] = '0;
      rows_back1[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++) nbhd[r][c] = '0;
    feed_col = 0;
    feed_row = 0;
    emit_col = 0;
    emit_row = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_px.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin : check_results
    median_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tlast) frames_done++;
      if (expected_px.size() == 0) begin
        $error("unexpected result: out_pixel %0d frame_last %0b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = expected_px.pop_front();
        if (m_axis_tdata !== want.pix) begin
          $error("out_pixel: expected %0d, got %0d", want.pix, m_axis_tdata);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_COLS) return MAX_COLS;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // advances the model by one accepted request; got says whether a result is due
  task automatic median_predict(input logic [7:0] pix, input logic is_pix,
                                output logic got, output median_out_t res);
    int unsigned w, h, row_cap, x;
    int          less, leq;
    logic        in_frame, first;
    logic [7:0]  v, up, mid;
    logic [7:0]  nine [9];
    w = active_width();
    h = active_height();
    row_cap = (h < 2) ? 2 : h;
    in_frame = (feed_row < h);
    got = 1'b0;
    res = '0;
    if (in_frame && !is_pix) return;
    v = in_frame ? pix : 8'd0;
    x = (feed_col < MAX_COLS) ? feed_col : 0;
    up = rows_back2[x];
    mid = rows_back1[x];
    rows_back2[x] = mid;
    rows_back1[x] = v;
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2] = up;
    nbhd[1][2] = mid;
    nbhd[2][2] = v;
    first = (w == 1) ? (feed_row == 2) : (feed_row == 1 && feed_col == 1);
    got = first || emit_row != 0 || emit_col != 0;
    if (feed_col + 1 >= w) begin
      feed_col = 0;
      if (feed_row < row_cap) feed_row++;
    end else begin
      feed_col++;
    end
    if (!got) return;
    if (emit_row >= 1 && emit_row + 1 < h && emit_col >= 1 && emit_col + 1 < w) begin
      for (int i = 0; i < 9; i++) nine[i] = nbhd[i / 3][i % 3];
      // fifth smallest: value with at most four below it and five or more at or below
      for (int i = 0; i < 9; i++) begin
        less = 0;
        leq = 0;
        for (int j = 0; j < 9; j++) begin
          if (nine[j] < nine[i]) less++;
          if (nine[j] <= nine[i]) leq++;
        end
        if (less <= 4 && leq > 4) res.pix = nine[i];
      end
    end else begin
      res.pix = nbhd[1][1];
    end
    res.last = (emit_row + 1 >= h) && (emit_col + 1 >= w);
    if (res.last) begin
      feed_col = 0;
      feed_row = 0;
      emit_col = 0;
      emit_row = 0;
    end else if (emit_col + 1 >= w) begin
      emit_col = 0;
      if (emit_row < 16'hFFFF) emit_row++;
    end else begin
      emit_col++;
    end
  endtask

  task automatic send_item(input logic [7:0] pix, input logic is_pix,
                           input check_kind_t kind, input median_out_t typed);
    logic        got;
    median_out_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= is_pix;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests++;
    median_predict(pix, is_pix, got, pred);
    if (kind == CHK_TYPED) expected_px.push_back(typed);
    else if (kind == CHK_MODEL && got) expected_px.push_back(pred);
  endtask

  // only called while no frame is in flight
  task automatic set_frame_size(input logic [15:0] wd, input logic [15:0] hd);
    cfg_we    <= 1'b1;
    cfg_index <= m3f_pkg::REG_FRAME_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= m3f_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg  = wd[m3f_pkg::FW_BITS-1:0];
    height_reg = hd[m3f_pkg::FH_BITS-1:0];
    reg_writes += 2;
  endtask

  // finish any partial frame, then hold off until all results are back
  task automatic frame_boundary();
    while (feed_col != 0 || feed_row != 0 || emit_col != 0 || emit_row != 0)
      send_item(8'($urandom_range(255)),
                (feed_row < active_height()) ? 1'b1 : 1'($urandom_range(1)), CHK_MODEL, '0);
    s_axis_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_frame(input bit keep_size);
    int unsigned w, h, tail, pick;
    logic [15:0] wd, hd;
    logic [7:0]  tone [4];
    logic [7:0]  p;
    bit          toned;
    if (!keep_size && $urandom_range(99) < 60) begin
      frame_boundary();
      wd = 16'($urandom_range(1, 12));
      if ($urandom_range(99) < 8) wd = '0;
      // upper bits of the data word lie outside the width register
      if ($urandom_range(3) == 0) wd[15:12] = 4'($urandom_range(15));
      hd = 16'($urandom_range(1, 9));
      if ($urandom_range(99) < 8) hd = '0;
      set_frame_size(wd, hd);
    end
    w = active_width();
    h = active_height();
    toned = ($urandom_range(2) == 0);
    tone[0] = 8'd0;
    tone[1] = 8'd255;
    tone[2] = 8'($urandom_range(255));
    tone[3] = 8'($urandom_range(255));
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 3) send_item(8'($urandom_range(255)), 1'b0, CHK_MODEL, '0);
      p = toned ? tone[$urandom_range(3)] : 8'($urandom_range(255));
      send_item(p, 1'b1, CHK_MODEL, '0);
      random_items++;
    end
    tail = w + 1;
    pick = $urandom_range(99);
    // a short tail lets the next frame's pixels do the draining
    if (pick < 5) tail = $urandom_range(tail - 1);
    else if (pick < 15) tail += $urandom_range(1, 3);
    for (int i = 0; i < tail; i++) begin
      send_item(8'($urandom_range(255)), ($urandom_range(99) < 25), CHK_MODEL, '0);
      random_items++;
    end
  endtask

  initial begin : stimulus
    directed_row_t row;
    int            mode_start;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    src_idle_pct = 31;
    dst_idle_pct = 87;

    set_frame_size(16'd3, 16'd3);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      send_item(row.pix, row.is_pix, row.kind, row.want);
    end
    frame_boundary();

    for (int idle_mode = 0; idle_mode < 3; idle_mode++) begin
      case (idle_mode)
        0: begin
          src_idle_pct = 31;
          dst_idle_pct = 87;
        end
        1: begin
          src_idle_pct = 87;
          dst_idle_pct = 31;
        end
        default: begin
          src_idle_pct = 0;
          dst_idle_pct = 0;
        end
      endcase
      mode_start = random_items;
      while (random_items - mode_start < ITEMS_PER_MODE) random_frame(1'b0);
      frame_boundary();
    end

    $display("%0d requests and %0d results over %0d frames, %0d register writes",
             requests, results_seen, frames_done, reg_writes);
    $display("frames from 1x1 up to 12 by 9, zero sizes, short and long tails, both-side stalls");
    if (errors == 0 && expected_px.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, expected_px.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/m3f_pkg.sv
design/m3f_line_buf.sv
design/m3f_median_sort.sv
design/median_3x3_filter.sv
design/m3f_checker.sv
tb/tb_median_3x3_filter.sv
